### rtl/bptc_pkg.sv
// Shared types and constants for the barometric compensation pipeline.
package bptc_pkg;

  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_CALIB_TEMP    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_PRESS_A = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_PRESS_B = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_PRESS_C = 8'd3;

  localparam int DIV_STEPS = 64;
  localparam int DEN_W     = 31;

  localparam logic [20:0] PRESS_FULL  = 21'd1048576;
  localparam logic [26:0] FINE_OFFSET = 27'd128000;
  localparam logic [11:0] DIV_SCALE   = 12'd3125;
  localparam logic [63:0] VAR1_BIAS   = 64'h0000_8000_0000_0000;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } calib_t;

  // Side data that travels with a request through the divider.
  typedef struct packed {
    logic        qneg;
    logic        inv;
    logic [15:0] temp;
  } side_t;

endpackage

### rtl/bptc_front.sv
// Fine temperature, pressure coefficients and divider operands (11 stages).
module bptc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [19:0]          raw_temp,
  input  logic [19:0]          raw_press,
  input  bptc_pkg::calib_t     calib,
  output logic                 out_valid,
  output logic [63:0]          num_mag,
  output logic [bptc_pkg::DEN_W-1:0] den_mag,
  output bptc_pkg::side_t      side
);

  logic [10:0] v_r;

  // stage 1
  logic signed [18:0] s1_a_r, s1_a_nxt;
  logic signed [16:0] s1_b_r, s1_b_nxt;
  logic [19:0]        s1_adcp_r;
  // stage 2
  logic signed [34:0] s2_pa_r;
  logic signed [33:0] s2_bb_r;
  logic [19:0]        s2_adcp_r;
  // stage 3
  logic signed [23:0] s3_vat_r;
  logic signed [37:0] s3_pb_r;
  logic [19:0]        s3_adcp_r;
  // stage 4
  logic signed [24:0] s4_fine_r;
  logic [19:0]        s4_adcp_r;
  // stage 5
  logic signed [27:0] f5;
  logic signed [19:0] tc;
  logic [15:0]        s5_temp_r, s5_temp_nxt;
  logic signed [26:0] s5_v_r;
  logic [19:0]        s5_adcp_r;
  // stage 6
  logic signed [53:0] s6_vsq_r;
  logic signed [42:0] s6_vp5_r;
  logic signed [42:0] s6_vp2_r;
  logic [15:0]        s6_temp_r;
  logic [19:0]        s6_adcp_r;
  // stage 7
  logic signed [69:0] m6, m3;
  logic [63:0]        s7_x6_r, s7_x3_r;
  logic signed [42:0] s7_vp5_r, s7_vp2_r;
  logic [15:0]        s7_temp_r;
  logic [19:0]        s7_adcp_r;
  // stage 8
  logic [63:0]        s8_vb_r, s8_va2_r;
  logic [15:0]        s8_temp_r;
  logic [19:0]        s8_adcp_r;
  // stage 9
  logic [63:0]        biased;
  logic [79:0]        my;
  logic [20:0]        pinv;
  logic [63:0]        s9_y_r, s9_pnum_r;
  logic [15:0]        s9_temp_r;
  // stage 10
  logic [75:0]        mn;
  logic [63:0]        s10_num_r;
  logic signed [30:0] s10_den_r;
  logic [15:0]        s10_temp_r;
  // stage 11
  logic [63:0]        s11_num_r;
  logic [30:0]        s11_den_r;
  bptc_pkg::side_t    s11_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[9:0], in_valid};
    end
  end

  assign s1_a_nxt = $signed({2'b00, raw_temp[19:3]}) - $signed({2'b00, calib.t1, 1'b0});
  assign s1_b_nxt = $signed({1'b0, raw_temp[19:4]}) - $signed({1'b0, calib.t1});

  assign f5 = (28'(s4_fine_r) <<< 2) + 28'(s4_fine_r) + 28'sd128;
  assign tc = $signed(f5[27:8]);

  always_comb begin
    if (tc > 20'sd32767) begin
      s5_temp_nxt = 16'h7FFF;
    end else if (tc < -20'sd32768) begin
      s5_temp_nxt = 16'h8000;
    end else begin
      s5_temp_nxt = tc[15:0];
    end
  end

  assign m6     = s6_vsq_r * $signed(calib.p6);
  assign m3     = s6_vsq_r * $signed(calib.p3);
  assign biased = s8_va2_r + bptc_pkg::VAR1_BIAS;
  assign my     = biased * calib.p1;
  assign pinv   = bptc_pkg::PRESS_FULL - {1'b0, s8_adcp_r};
  assign mn     = s9_pnum_r * bptc_pkg::DIV_SCALE;

  always_ff @(posedge clk) begin
    s1_a_r    <= s1_a_nxt;
    s1_b_r    <= s1_b_nxt;
    s1_adcp_r <= raw_press;

    s2_pa_r   <= s1_a_r * $signed(calib.t2);
    s2_bb_r   <= s1_b_r * s1_b_r;
    s2_adcp_r <= s1_adcp_r;

    s3_vat_r  <= $signed(s2_pa_r[34:11]);
    s3_pb_r   <= $signed(s2_bb_r[33:12]) * $signed(calib.t3);
    s3_adcp_r <= s2_adcp_r;

    s4_fine_r <= $signed({s3_vat_r[23], s3_vat_r}) + $signed({s3_pb_r[37], s3_pb_r[37:14]});
    s4_adcp_r <= s3_adcp_r;

    s5_temp_r <= s5_temp_nxt;
    s5_v_r    <= 27'(s4_fine_r) - $signed(bptc_pkg::FINE_OFFSET);
    s5_adcp_r <= s4_adcp_r;

    s6_vsq_r  <= s5_v_r * s5_v_r;
    s6_vp5_r  <= s5_v_r * $signed(calib.p5);
    s6_vp2_r  <= s5_v_r * $signed(calib.p2);
    s6_temp_r <= s5_temp_r;
    s6_adcp_r <= s5_adcp_r;

    s7_x6_r   <= m6[63:0];
    s7_x3_r   <= m3[63:0];
    s7_vp5_r  <= s6_vp5_r;
    s7_vp2_r  <= s6_vp2_r;
    s7_temp_r <= s6_temp_r;
    s7_adcp_r <= s6_adcp_r;

    s8_vb_r   <= s7_x6_r + (64'(s7_vp5_r) << 17) + (64'(calib.p4) << 35);
    s8_va2_r  <= {{8{s7_x3_r[63]}}, s7_x3_r[63:8]} + (64'(s7_vp2_r) << 12);
    s8_temp_r <= s7_temp_r;
    s8_adcp_r <= s7_adcp_r;

    s9_y_r    <= my[63:0];
    s9_pnum_r <= (64'(pinv) << 31) - s8_vb_r;
    s9_temp_r <= s8_temp_r;

    s10_num_r  <= mn[63:0];
    s10_den_r  <= $signed(s9_y_r[63:33]);
    s10_temp_r <= s9_temp_r;

    // fold signs to magnitudes for the divider
    s11_num_r       <= s10_num_r[63] ? (64'd0 - s10_num_r) : s10_num_r;
    s11_den_r       <= s10_den_r[30] ? (31'd0 - s10_den_r) : s10_den_r;
    s11_side_r.qneg <= s10_num_r[63] ^ s10_den_r[30];
    s11_side_r.inv  <= (s10_den_r == 31'sd0);
    s11_side_r.temp <= s10_temp_r;
  end

  assign out_valid = v_r[10];
  assign num_mag   = s11_num_r;
  assign den_mag   = s11_den_r;
  assign side      = s11_side_r;

endmodule

### rtl/bptc_div.sv
// Pipelined restoring divider: one quotient bit per stage.
module bptc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [63:0]                num,
  input  logic [bptc_pkg::DEN_W-1:0] den,
  input  bptc_pkg::side_t            in_side,
  output logic                       out_valid,
  output logic [63:0]                quot,
  output bptc_pkg::side_t            out_side
);

  localparam int N = bptc_pkg::DIV_STEPS;
  localparam int W = bptc_pkg::DEN_W;

  logic [N-1:0]    v_r;
  logic [63:0]     nq_r   [N];
  logic [W-1:0]    rem_r  [N];
  logic [W-1:0]    den_r  [N];
  bptc_pkg::side_t side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic            v_i;
    logic [63:0]     nq_i;
    logic [W-1:0]    rem_i;
    logic [W-1:0]    den_i;
    bptc_pkg::side_t side_i;
    logic [W:0]      trial;
    logic [W:0]      diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign nq_i   = num;
      assign rem_i  = '0;
      assign den_i  = den;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_r[k-1];
      assign nq_i   = nq_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign den_i  = den_r[k-1];
      assign side_i = side_r[k-1];
    end

    assign trial = {rem_i, nq_i[63]};
    assign ge    = trial >= {1'b0, den_i};
    assign diff  = trial - {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_i;
      end
    end

    // shift numerator out, quotient bit in
    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? diff[W-1:0] : trial[W-1:0];
      nq_r[k]   <= {nq_i[62:0], ge};
      den_r[k]  <= den_i;
      side_r[k] <= side_i;
    end
  end

  assign out_valid = v_r[N-1];
  assign quot      = nq_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

### rtl/bptc_back.sv
// Pressure correction terms and output saturation (5 stages).
module bptc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [63:0]      quot,
  input  bptc_pkg::side_t  in_side,
  input  bptc_pkg::calib_t calib,
  output logic             out_valid,
  output logic [15:0]      temp_centi,
  output logic [31:0]      press_q24_8,
  output logic             press_invalid
);

  logic [4:0] v_r;

  logic [63:0]        b0_p_r;
  bptc_pkg::side_t    b0_side_r;

  logic [31:0]        xl;
  logic signed [18:0] xh;
  logic signed [51:0] lh;
  logic signed [79:0] m8;
  logic [63:0]        b1_ll_r;
  logic [30:0]        b1_lh_r;
  logic [63:0]        b1_m8_r;
  logic [63:0]        b1_p_r;
  bptc_pkg::side_t    b1_side_r;

  logic [63:0]        b2_sq_r, b2_vb_r, b2_p_r;
  bptc_pkg::side_t    b2_side_r;

  logic signed [79:0] m9;
  logic [63:0]        b3_m_r, b3_vb_r, b3_p_r;
  bptc_pkg::side_t    b3_side_r;

  logic [63:0]        sum, s;
  logic [31:0]        press_nxt;
  logic [15:0]        temp_r;
  logic [31:0]        press_r;
  logic               inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  // x = p >>> 13 split as xh:xl; x*x mod 2^64 = xl*xl + (xh*xl << 33)
  assign xl = b0_p_r[44:13];
  assign xh = $signed(b0_p_r[63:45]);
  assign lh = $signed({1'b0, xl}) * xh;
  assign m8 = $signed(b0_p_r) * $signed(calib.p8);
  assign m9 = $signed(b2_sq_r) * $signed(calib.p9);

  assign sum = b3_p_r + {{25{b3_m_r[63]}}, b3_m_r[63:25]} + b3_vb_r;
  assign s   = {{8{sum[63]}}, sum[63:8]} + (64'(calib.p7) << 4);

  always_comb begin
    if (b3_side_r.inv || s[63]) begin
      press_nxt = '0;
    end else if (|s[62:32]) begin
      press_nxt = 32'hFFFF_FFFF;
    end else begin
      press_nxt = s[31:0];
    end
  end

  always_ff @(posedge clk) begin
    b0_p_r    <= in_side.qneg ? (64'd0 - quot) : quot;
    b0_side_r <= in_side;

    b1_ll_r   <= xl * xl;
    b1_lh_r   <= lh[30:0];
    b1_m8_r   <= m8[63:0];
    b1_p_r    <= b0_p_r;
    b1_side_r <= b0_side_r;

    b2_sq_r   <= b1_ll_r + {b1_lh_r, 33'd0};
    b2_vb_r   <= {{19{b1_m8_r[63]}}, b1_m8_r[63:19]};
    b2_p_r    <= b1_p_r;
    b2_side_r <= b1_side_r;

    b3_m_r    <= m9[63:0];
    b3_vb_r   <= b2_vb_r;
    b3_p_r    <= b2_p_r;
    b3_side_r <= b2_side_r;

    temp_r    <= b3_side_r.temp;
    press_r   <= press_nxt;
    inv_r     <= b3_side_r.inv;
  end

  assign out_valid     = v_r[4];
  assign temp_centi    = temp_r;
  assign press_q24_8   = press_r;
  assign press_invalid = inv_r;

endmodule

### rtl/baro_temp_pressure_compensation.sv
// Barometric compensation: each accepted request runs through front, divider and back to the out_valid strobe.
// Throughput one request per cycle; busy stays low, the pipeline never stalls.
// Depth: 11 front stages, a 64-stage divider (one quotient bit each), 5 back stages.
// Reset (rst_n low, synchronous) clears all valid bits and calibration registers.
// The receiver cannot stall; each result shows for one cycle with out_valid.
module baro_temp_pressure_compensation (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [19:0]                    in_raw_temp,
  input  logic [19:0]                    in_raw_press,
  output logic                           out_valid,
  output logic signed [15:0]             out_temp_centi,
  output logic [31:0]                    out_press_q24_8,
  output logic                           out_press_invalid,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bptc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data
);

  logic [47:0] calib_temp_r;
  logic [63:0] calib_press_a_r;
  logic [63:0] calib_press_b_r;
  logic [15:0] calib_press_c_r;

  bptc_pkg::calib_t calib;

  logic                       f_valid;
  logic [63:0]                f_num;
  logic [bptc_pkg::DEN_W-1:0] f_den;
  bptc_pkg::side_t            f_side;
  logic                       d_valid;
  logic [63:0]                d_quot;
  bptc_pkg::side_t            d_side;
  logic [15:0]                temp_w;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_temp_r    <= '0;
      calib_press_a_r <= '0;
      calib_press_b_r <= '0;
      calib_press_c_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bptc_pkg::REG_CALIB_TEMP:    calib_temp_r    <= cfg_data[47:0];
        bptc_pkg::REG_CALIB_PRESS_A: calib_press_a_r <= cfg_data;
        bptc_pkg::REG_CALIB_PRESS_B: calib_press_b_r <= cfg_data;
        bptc_pkg::REG_CALIB_PRESS_C: calib_press_c_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign calib.t1 = calib_temp_r[15:0];
  assign calib.t2 = calib_temp_r[31:16];
  assign calib.t3 = calib_temp_r[47:32];
  assign calib.p1 = calib_press_a_r[15:0];
  assign calib.p2 = calib_press_a_r[31:16];
  assign calib.p3 = calib_press_a_r[47:32];
  assign calib.p4 = calib_press_a_r[63:48];
  assign calib.p5 = calib_press_b_r[15:0];
  assign calib.p6 = calib_press_b_r[31:16];
  assign calib.p7 = calib_press_b_r[47:32];
  assign calib.p8 = calib_press_b_r[63:48];
  assign calib.p9 = calib_press_c_r;

  bptc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .raw_temp  (in_raw_temp),
    .raw_press (in_raw_press),
    .calib     (calib),
    .out_valid (f_valid),
    .num_mag   (f_num),
    .den_mag   (f_den),
    .side      (f_side)
  );

  bptc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .num       (f_num),
    .den       (f_den),
    .in_side   (f_side),
    .out_valid (d_valid),
    .quot      (d_quot),
    .out_side  (d_side)
  );

  bptc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (d_valid),
    .quot          (d_quot),
    .in_side       (d_side),
    .calib         (calib),
    .out_valid     (out_valid),
    .temp_centi    (temp_w),
    .press_q24_8   (out_press_q24_8),
    .press_invalid (out_press_invalid)
  );

  assign out_temp_centi = $signed(temp_w);

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 80))
    else $error("result strobe without matching request");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_press_invalid) |-> (out_press_q24_8 == 32'd0))
    else $error("invalid pressure not forced to zero");

  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result strobe right after reset");
`endif

endmodule
